### hw/rtl/page_framebuffer_i2c_sequencer_core_assert.svh
// Assertion macros for the frame buffer sequencer.
// All of them sample on clk and are disabled while rst_n is low.
`ifndef PAGE_FRAMEBUFFER_I2C_SEQUENCER_CORE_ASSERT_SVH
`define PAGE_FRAMEBUFFER_I2C_SEQUENCER_CORE_ASSERT_SVH

// Same-cycle implication.
`define PFB_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PFB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/pfbseq_pkg.sv
`timescale 1ns / 1ps
package pfbseq_pkg;

  // Request kinds
  localparam logic [1:0] KIND_DRAW    = 2'd0;
  localparam logic [1:0] KIND_FLUSH   = 2'd1;
  localparam logic [1:0] KIND_CLEAR   = 2'd2;
  localparam logic [1:0] KIND_ADVANCE = 2'd3;

  // Bus symbols
  localparam logic [1:0] SYM_NONE  = 2'd0;
  localparam logic [1:0] SYM_START = 2'd1;
  localparam logic [1:0] SYM_BYTE  = 2'd2;
  localparam logic [1:0] SYM_STOP  = 2'd3;

  // Status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_RANGE = 2'd1;
  localparam logic [1:0] STATUS_BUSY  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_WIDTH_LIMIT  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT_LIMIT = 2'd1;
  localparam logic [1:0] CFG_AUTO_FLUSH   = 2'd2;

  // Bus byte constants
  localparam logic [7:0] BYTE_ZERO      = 8'h00;
  localparam logic [7:0] CMD_PREFIX     = 8'h80;
  localparam logic [7:0] DATA_PREFIX    = 8'hC0;
  localparam logic [7:0] STREAM_PREFIX  = 8'h40;
  localparam logic [7:0] PAGE_CMD       = 8'hB0;
  localparam logic [7:0] COL_HI_CMD     = 8'h10;
  localparam logic [7:0] LOW_NIBBLE     = 8'h0F;
  localparam logic [7:0] FILL_ON        = 8'hFF;

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] pos_x;
    logic [5:0] pos_y;
    logic       pixel_on;
  } in_item_t;

  typedef struct packed {
    logic [1:0] sym_kind;
    logic [7:0] sym_byte;
    logic [1:0] status;
    logic       last;
  } out_item_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_READ,
    PH_EXEC
  } phase_t;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_CELL,
    MODE_FLUSH,
    MODE_CLEAR
  } mode_t;

  // Byte source select of a control word
  typedef enum logic [2:0] {
    SRC_CONST,
    SRC_CELL_PAGE,
    SRC_COL_HI,
    SRC_COL_LO,
    SRC_CELL_DATA,
    SRC_PAGE_CMD,
    SRC_STREAM
  } src_t;

  // Sequencing of a control word
  typedef enum logic [1:0] {
    OP_NEXT,
    OP_COL_LOOP,
    OP_CELL_END,
    OP_PAGE_END
  } seq_op_t;

  localparam int UPC_W = 5;
  typedef logic [UPC_W-1:0] upc_t;

  localparam upc_t UPC_CELL = 5'd0;
  localparam upc_t UPC_PAGE = 5'd10;

  typedef struct packed {
    logic [1:0] sym;
    src_t       src;
    logic [7:0] konst;
    seq_op_t    op;
  } ucode_t;

  // Commands from the request handler to the sequencer
  typedef struct packed {
    logic       start_cell;
    logic       start_flush;
    logic       start_clear;
    logic       step;
    logic [6:0] cell_col;
    logic [2:0] cell_page;
    logic [7:0] cell_data;
    logic       fill_on;
  } useq_cmd_t;

  // Symbol the sequencer presents for its current step
  typedef struct packed {
    logic [1:0] sym_kind;
    logic [7:0] sym_byte;
    logic       last;
  } sym_t;

  // Transfer microprogram. Cell transfer at UPC_CELL, page transfer at UPC_PAGE.
  function automatic ucode_t ucode_rom(input upc_t upc);
    ucode_t cw;
    cw = '{sym: SYM_NONE, src: SRC_CONST, konst: BYTE_ZERO, op: OP_CELL_END};
    case (upc)
      5'd0:  cw = '{sym: SYM_START, src: SRC_CONST,     konst: BYTE_ZERO,     op: OP_NEXT};
      5'd1:  cw = '{sym: SYM_BYTE,  src: SRC_CONST,     konst: CMD_PREFIX,    op: OP_NEXT};
      5'd2:  cw = '{sym: SYM_BYTE,  src: SRC_CELL_PAGE, konst: BYTE_ZERO,     op: OP_NEXT};
      5'd3:  cw = '{sym: SYM_BYTE,  src: SRC_CONST,     konst: CMD_PREFIX,    op: OP_NEXT};
      5'd4:  cw = '{sym: SYM_BYTE,  src: SRC_COL_HI,    konst: BYTE_ZERO,     op: OP_NEXT};
      5'd5:  cw = '{sym: SYM_BYTE,  src: SRC_CONST,     konst: CMD_PREFIX,    op: OP_NEXT};
      5'd6:  cw = '{sym: SYM_BYTE,  src: SRC_COL_LO,    konst: BYTE_ZERO,     op: OP_NEXT};
      5'd7:  cw = '{sym: SYM_BYTE,  src: SRC_CONST,     konst: DATA_PREFIX,   op: OP_NEXT};
      5'd8:  cw = '{sym: SYM_BYTE,  src: SRC_CELL_DATA, konst: BYTE_ZERO,     op: OP_NEXT};
      5'd9:  cw = '{sym: SYM_STOP,  src: SRC_CONST,     konst: BYTE_ZERO,     op: OP_CELL_END};
      5'd10: cw = '{sym: SYM_START, src: SRC_CONST,     konst: BYTE_ZERO,     op: OP_NEXT};
      5'd11: cw = '{sym: SYM_BYTE,  src: SRC_CONST,     konst: CMD_PREFIX,    op: OP_NEXT};
      5'd12: cw = '{sym: SYM_BYTE,  src: SRC_PAGE_CMD,  konst: BYTE_ZERO,     op: OP_NEXT};
      5'd13: cw = '{sym: SYM_BYTE,  src: SRC_CONST,     konst: CMD_PREFIX,    op: OP_NEXT};
      5'd14: cw = '{sym: SYM_BYTE,  src: SRC_CONST,     konst: BYTE_ZERO,     op: OP_NEXT};
      5'd15: cw = '{sym: SYM_BYTE,  src: SRC_CONST,     konst: CMD_PREFIX,    op: OP_NEXT};
      5'd16: cw = '{sym: SYM_BYTE,  src: SRC_CONST,     konst: COL_HI_CMD,    op: OP_NEXT};
      5'd17: cw = '{sym: SYM_BYTE,  src: SRC_CONST,     konst: STREAM_PREFIX, op: OP_NEXT};
      5'd18: cw = '{sym: SYM_BYTE,  src: SRC_STREAM,    konst: BYTE_ZERO,     op: OP_COL_LOOP};
      5'd19: cw = '{sym: SYM_STOP,  src: SRC_CONST,     konst: BYTE_ZERO,     op: OP_PAGE_END};
      default: cw = '{sym: SYM_NONE, src: SRC_CONST, konst: BYTE_ZERO, op: OP_CELL_END};
    endcase
    return cw;
  endfunction

endpackage

### hw/rtl/page_framebuffer_i2c_sequencer_core.sv
`timescale 1ns / 1ps
// Page-addressed monochrome frame buffer with a bus symbol sequencer.
// Input channel in_valid/in_stall/in_item carries requests: draw a point,
// flush the store, clear the screen, or advance the queued transfer by one
// symbol. Output channel out_valid/out_stall/out_item returns exactly one
// result transaction per request (symbol, byte, status, last mark).
// cfg_wr_en/cfg_index/cfg_wdata write the width limit, the height limit and
// the auto send flag; write them only while no request is in flight.
// Each request is captured, then the frame store is read (registered read
// port, state PH_READ), then state PH_EXEC executes the microcode step and
// loads the output register that drives out_valid. One request is in
// flight at a time, so the input takes no new transaction until the last
// one has left the execute state.
// While the receiver stalls, the result waits in the output register and
// the next request may still be accepted; it parks in its execute cycle
// until the output register frees up.
// After reset the store is zeroed by a sweep over all COLUMNS * 2^PW entries
// (PW = max(1, ceil(log2 PAGES)); 1024 by default); in_stall stays high meanwhile.
module page_framebuffer_i2c_sequencer_core #(
  parameter int COLUMNS = 128,
  parameter int PAGES   = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  pfbseq_pkg::in_item_t  in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output pfbseq_pkg::out_item_t out_item,
  input  logic                  cfg_wr_en,
  input  logic [1:0]            cfg_index,
  input  logic [7:0]            cfg_wdata
);

  import pfbseq_pkg::*;

  `include "page_framebuffer_i2c_sequencer_core_assert.svh"

  localparam int CW    = $clog2(COLUMNS);
  localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int AW    = CW + PW;
  localparam int DEPTH = COLUMNS * (2 ** PW);

  // Configuration registers
  logic [7:0] width_limit_r;
  logic [6:0] height_limit_r;
  logic       cell_send_r;

  // Request phase
  phase_t     ph_r;
  phase_t     ph_nxt;
  in_item_t   item_r;
  logic       in_fire;
  logic       slot_free;
  logic       ex_fire;

  // Output register
  logic       out_valid_r;
  logic       out_valid_nxt;
  out_item_t  out_item_r;
  out_item_t  res;

  // Frame store and sequencer hookup
  logic          st_rd_en;
  logic [AW-1:0] st_addr;
  logic [7:0]    st_rd_data;
  logic          st_wr_en;
  logic [7:0]    st_wr_data;
  logic          clearing;
  useq_cmd_t     cmd;
  sym_t          sym;
  logic          seq_busy;
  logic [CW-1:0] stream_col;
  logic [2:0]    stream_page;

  // Draw decode
  logic [2:0]    draw_pg;
  logic [7:0]    bit_mask;
  logic [7:0]    cell_new;
  logic          draw_bad;

  // ---------------------------------------------------------------------------
  // Configuration port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_limit_r  <= 8'd128;
      height_limit_r <= 7'd64;
      cell_send_r    <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_WIDTH_LIMIT:  width_limit_r  <= cfg_wdata;
        CFG_HEIGHT_LIMIT: height_limit_r <= cfg_wdata[6:0];
        CFG_AUTO_FLUSH:   cell_send_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Request phase: capture, store read, execute
  assign in_stall  = clearing || (ph_r != PH_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    ph_nxt = ph_r;
    unique case (ph_r)
      PH_IDLE: if (in_fire) ph_nxt = PH_READ;
      PH_READ: ph_nxt = PH_EXEC;
      PH_EXEC: if (slot_free) ph_nxt = PH_IDLE;
      default: ph_nxt = PH_IDLE;
    endcase
  end

  always_comb begin
    st_rd_en = (ph_r == PH_READ);
    ex_fire  = (ph_r == PH_EXEC) && slot_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_IDLE;
    end else begin
      ph_r <= ph_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= in_item;
    end
  end

  // ---------------------------------------------------------------------------
  // Store address: the stream position for an advance, the point otherwise.
  // Entry index is {column, page}.
  assign draw_pg = item_r.pos_y[5:3];
  assign st_addr = (item_r.kind == KIND_ADVANCE) ?
                   {stream_col, stream_page[PW-1:0]} :
                   {item_r.pos_x[CW-1:0], draw_pg[PW-1:0]};

  assign bit_mask = 8'b1 << item_r.pos_y[2:0];
  assign cell_new = item_r.pixel_on ? (st_rd_data | bit_mask) : (st_rd_data & ~bit_mask);

  // Point must sit inside both the configured limits and the store itself
  assign draw_bad = ({1'b0, item_r.pos_x} >= width_limit_r) ||
                    ({1'b0, item_r.pos_y} >= height_limit_r) ||
                    ({1'b0, item_r.pos_x} >= 8'(COLUMNS)) ||
                    ({1'b0, draw_pg} >= 4'(PAGES));

  // ---------------------------------------------------------------------------
  // Execute: result, store write-back and sequencer commands
  always_comb begin
    res        = '{sym_kind: SYM_NONE, sym_byte: BYTE_ZERO, status: STATUS_OK, last: 1'b0};
    cmd        = '0;
    st_wr_en   = 1'b0;
    st_wr_data = cell_new;
    cmd.cell_col  = item_r.pos_x;
    cmd.cell_page = draw_pg;
    cmd.cell_data = cell_new;
    cmd.fill_on   = item_r.pixel_on;
    if (ex_fire) begin
      if (item_r.kind == KIND_ADVANCE) begin
        // advance while idle answers with no symbol
        if (seq_busy) begin
          cmd.step     = 1'b1;
          res.sym_kind = sym.sym_kind;
          res.sym_byte = sym.sym_byte;
          res.last     = sym.last;
        end
      end else if (seq_busy) begin
        res.status = STATUS_BUSY;
      end else if (item_r.kind == KIND_DRAW) begin
        if (draw_bad) begin
          res.status = STATUS_RANGE;
        end else begin
          st_wr_en       = 1'b1;
          cmd.start_cell = cell_send_r;
        end
      end else begin
        cmd.start_flush = (item_r.kind == KIND_FLUSH);
        cmd.start_clear = (item_r.kind == KIND_CLEAR);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ex_fire) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ex_fire) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // ---------------------------------------------------------------------------
  pfbseq_store #(
    .AW    (AW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (st_rd_en),
    .rd_addr  (st_addr),
    .rd_data  (st_rd_data),
    .wr_en    (st_wr_en),
    .wr_addr  (st_addr),
    .wr_data  (st_wr_data),
    .clearing (clearing)
  );

  pfbseq_useq #(
    .COLUMNS (COLUMNS),
    .PAGES   (PAGES),
    .CW      (CW)
  ) u_useq (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .rd_data     (st_rd_data),
    .sym         (sym),
    .busy        (seq_busy),
    .stream_col  (stream_col),
    .stream_page (stream_page)
  );

  // ---------------------------------------------------------------------------
  // Checks
  `PFB_ASSERT_IMP(a_sweep_holds_input, clearing, in_stall, "request accepted during store sweep")
  `PFB_ASSERT_IMP(a_last_on_stop, out_valid && out_item.last, out_item.sym_kind == SYM_STOP, "last mark on a non-stop symbol")
  `PFB_ASSERT_NEXT(a_read_then_exec, ph_r == PH_READ, ph_r == PH_EXEC, "store read not followed by execute")
  `PFB_ASSERT_IMP(a_write_in_exec, st_wr_en, ex_fire && !clearing, "store write outside execute")

endmodule

### hw/rtl/pfbseq_store.sv
`timescale 1ns / 1ps
module pfbseq_store #(
  parameter int AW    = 10,
  parameter int DEPTH = 1024
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  output logic          clearing
);

  logic [7:0]    mem [DEPTH];
  logic [7:0]    rd_data_r;
  logic          clr_active_r;
  logic          clr_active_nxt;
  logic [AW-1:0] clr_addr_r;
  logic [AW-1:0] clr_addr_nxt;
  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;

  // zeroing sweep after reset, one entry per cycle
  always_comb begin
    clr_active_nxt = clr_active_r;
    clr_addr_nxt   = clr_addr_r;
    if (clr_active_r) begin
      clr_addr_nxt = clr_addr_r + AW'(1);
      if (clr_addr_r == AW'(DEPTH - 1)) begin
        clr_active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else begin
      clr_active_r <= clr_active_nxt;
      clr_addr_r   <= clr_addr_nxt;
    end
  end

  assign we    = clr_active_r || wr_en;
  assign waddr = clr_active_r ? clr_addr_r : wr_addr;
  assign wdata = clr_active_r ? 8'h00 : wr_data;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data  = rd_data_r;
  assign clearing = clr_active_r;

endmodule

### hw/rtl/pfbseq_useq.sv
`timescale 1ns / 1ps
module pfbseq_useq #(
  parameter int COLUMNS = 128,
  parameter int PAGES   = 8,
  parameter int CW      = 7
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pfbseq_pkg::useq_cmd_t cmd,
  input  logic [7:0]            rd_data,
  output pfbseq_pkg::sym_t      sym,
  output logic                  busy,
  output logic [CW-1:0]         stream_col,
  output logic [2:0]            stream_page
);

  import pfbseq_pkg::*;

  mode_t         mode_r;
  mode_t         mode_nxt;
  upc_t          upc_r;
  upc_t          upc_nxt;
  logic [2:0]    page_r;
  logic [2:0]    page_nxt;
  logic [CW-1:0] col_r;
  logic [CW-1:0] col_nxt;
  logic [6:0]    cell_col_r;
  logic [2:0]    cell_page_r;
  logic [7:0]    cell_data_r;
  logic [7:0]    fill_r;
  ucode_t        cw;
  logic          col_last;
  logic          page_last;

  assign cw        = ucode_rom(upc_r);
  assign col_last  = (col_r == CW'(COLUMNS - 1));
  assign page_last = (page_r == 3'(PAGES - 1));

  // next state: mode, step counter, column and page counters
  always_comb begin
    mode_nxt = mode_r;
    upc_nxt  = upc_r;
    page_nxt = page_r;
    col_nxt  = col_r;
    if (cmd.start_cell) begin
      mode_nxt = MODE_CELL;
      upc_nxt  = UPC_CELL;
    end else if (cmd.start_flush || cmd.start_clear) begin
      mode_nxt = cmd.start_clear ? MODE_CLEAR : MODE_FLUSH;
      upc_nxt  = UPC_PAGE;
      page_nxt = '0;
      col_nxt  = '0;
    end else if (cmd.step) begin
      unique case (cw.op)
        OP_NEXT: begin
          upc_nxt = upc_r + UPC_W'(1);
        end
        OP_COL_LOOP: begin
          if (col_last) begin
            col_nxt = '0;
            upc_nxt = upc_r + UPC_W'(1);
          end else begin
            col_nxt = col_r + CW'(1);
          end
        end
        OP_CELL_END: begin
          mode_nxt = MODE_IDLE;
          upc_nxt  = UPC_CELL;
        end
        OP_PAGE_END: begin
          if (page_last) begin
            mode_nxt = MODE_IDLE;
            page_nxt = '0;
            upc_nxt  = UPC_CELL;
          end else begin
            page_nxt = page_r + 3'd1;
            upc_nxt  = UPC_PAGE;
          end
        end
      endcase
    end
  end

  // outputs: symbol of the current control word
  always_comb begin
    sym.sym_kind = cw.sym;
    sym.last     = (cw.op == OP_CELL_END) || ((cw.op == OP_PAGE_END) && page_last);
    unique case (cw.src)
      SRC_CONST:     sym.sym_byte = cw.konst;
      SRC_CELL_PAGE: sym.sym_byte = PAGE_CMD | {5'b0, cell_page_r};
      SRC_COL_HI:    sym.sym_byte = COL_HI_CMD | {5'b0, cell_col_r[6:4]};
      SRC_COL_LO:    sym.sym_byte = {1'b0, cell_col_r} & LOW_NIBBLE;
      SRC_CELL_DATA: sym.sym_byte = cell_data_r;
      SRC_PAGE_CMD:  sym.sym_byte = PAGE_CMD | {5'b0, page_r};
      SRC_STREAM:    sym.sym_byte = (mode_r == MODE_CLEAR) ? fill_r : rd_data;
      default:       sym.sym_byte = BYTE_ZERO;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      upc_r  <= UPC_CELL;
      page_r <= '0;
      col_r  <= '0;
    end else begin
      mode_r <= mode_nxt;
      upc_r  <= upc_nxt;
      page_r <= page_nxt;
      col_r  <= col_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_cell) begin
      cell_col_r  <= cmd.cell_col;
      cell_page_r <= cmd.cell_page;
      cell_data_r <= cmd.cell_data;
    end
    if (cmd.start_clear) begin
      fill_r <= cmd.fill_on ? FILL_ON : BYTE_ZERO;
    end
  end

  assign busy        = (mode_r != MODE_IDLE);
  assign stream_col  = col_r;
  assign stream_page = page_r;

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
module tb;
  import pfbseq_pkg::*;

  // Store geometry; the block is built with the same values.
  localparam int NCOL     = 128;
  localparam int NPAGE    = 8;
  localparam int HDR_LEN  = 8;           // start plus seven header bytes of a page
  localparam int PAGE_SYMS = HDR_LEN + NCOL + 1;
  // About 1350 transactions, each paying the request time,
  // a sender gap and a long receiver stall, plus the reset sweep.
  localparam int CYCLE_LIMIT = 150000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;
  logic       cfg_wr_en = 1'b0;
  logic [1:0] cfg_index = CFG_WIDTH_LIMIT;
  logic [7:0] cfg_wdata = '0;

  always #1 clk = ~clk;

  page_framebuffer_i2c_sequencer_core #(
    .COLUMNS(NCOL),
    .PAGES(NPAGE)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // ---------------------------------------------------------------------
  // Shadow of the block: frame store, transfer sequencer and registers.
  // ---------------------------------------------------------------------
  logic [7:0] pix_store [NCOL*NPAGE];
  logic [7:0] fill_val;
  mode_t      xfer_mode;
  logic [2:0] page_num;
  logic [7:0] seq_pos;
  logic [6:0] cell_col;
  logic [2:0] cell_pg;
  logic [7:0] cell_byte;

  logic [7:0] lim_w = 8'd128;
  logic [6:0] lim_h = 7'd64;
  logic       auto_send = 1'b0;

  initial begin
    foreach (pix_store[i]) pix_store[i] = '0;
    fill_val  = '0;
    xfer_mode = MODE_IDLE;
    page_num  = '0;
    seq_pos   = '0;
    cell_col  = '0;
    cell_pg   = '0;
    cell_byte = '0;
  end

  // Applies one request to the shadow state and returns the symbol
  // transaction the block must answer with.
  function automatic out_item_t step_sequencer(in_item_t rq);
    out_item_t r;
    int        pg;
    int        bitn;
    int        idx;
    int        col;
    logic [7:0] v;
    r = '{sym_kind: SYM_NONE, sym_byte: BYTE_ZERO, status: STATUS_OK, last: 1'b0};
    if (rq.kind == KIND_ADVANCE) begin
      if (xfer_mode == MODE_CELL) begin
        r.sym_kind = SYM_BYTE;
        case (seq_pos)
          8'd0: r.sym_kind = SYM_START;
          8'd1, 8'd3, 8'd5: r.sym_byte = CMD_PREFIX;
          8'd2: r.sym_byte = PAGE_CMD | {5'd0, cell_pg};
          8'd4: r.sym_byte = COL_HI_CMD | {5'd0, cell_col[6:4]};
          8'd6: r.sym_byte = {1'b0, cell_col} & LOW_NIBBLE;
          8'd7: r.sym_byte = DATA_PREFIX;
          8'd8: r.sym_byte = cell_byte;
          default: begin
            r.sym_kind = SYM_STOP;
            r.last     = 1'b1;
            xfer_mode  = MODE_IDLE;
          end
        endcase
        seq_pos = (r.sym_kind == SYM_STOP) ? 8'd0 : seq_pos + 8'd1;
      end else if (xfer_mode != MODE_IDLE) begin
        r.sym_kind = SYM_BYTE;
        if (seq_pos == 8'd0) begin
          r.sym_kind = SYM_START;
        end else if (int'(seq_pos) < HDR_LEN) begin
          // prefix / command pairs: page, column low 0, column high 0, stream
          case (seq_pos)
            8'd1, 8'd3, 8'd5: r.sym_byte = CMD_PREFIX;
            8'd2: r.sym_byte = PAGE_CMD | {5'd0, page_num};
            8'd4: r.sym_byte = BYTE_ZERO;
            8'd6: r.sym_byte = COL_HI_CMD;
            default: r.sym_byte = STREAM_PREFIX;
          endcase
        end else if (int'(seq_pos) < HDR_LEN + NCOL) begin
          col = int'(seq_pos) - HDR_LEN;
          if (xfer_mode == MODE_FLUSH && int'(page_num) < NPAGE)
            r.sym_byte = pix_store[col*NPAGE + int'(page_num)];
          else if (xfer_mode == MODE_CLEAR)
            r.sym_byte = fill_val;
        end else begin
          r.sym_kind = SYM_STOP;
          if (int'(page_num) + 1 >= NPAGE) begin
            r.last    = 1'b1;
            xfer_mode = MODE_IDLE;
            page_num  = '0;
          end else begin
            page_num = page_num + 3'd1;
          end
        end
        seq_pos = (r.sym_kind == SYM_STOP) ? 8'd0 : seq_pos + 8'd1;
      end
      return r;
    end
    if (xfer_mode != MODE_IDLE) begin
      r.status = STATUS_BUSY;
      return r;
    end
    if (rq.kind == KIND_DRAW) begin
      pg   = int'(rq.pos_y) >> 3;
      bitn = int'(rq.pos_y) & 7;
      if (int'(rq.pos_x) >= int'(lim_w) || int'(rq.pos_y) >= int'(lim_h) ||
          int'(rq.pos_x) >= NCOL || pg >= NPAGE) begin
        r.status = STATUS_RANGE;
        return r;
      end
      idx = int'(rq.pos_x) * NPAGE + pg;
      v = pix_store[idx];
      v[bitn] = rq.pixel_on;
      pix_store[idx] = v;
      if (auto_send) begin
        cell_col  = rq.pos_x;
        cell_pg   = pg[2:0];
        cell_byte = v;
        seq_pos   = '0;
        xfer_mode = MODE_CELL;
      end
    end else begin
      // clear only picks the fill level, the store is left alone
      if (rq.kind == KIND_CLEAR) fill_val = rq.pixel_on ? FILL_ON : BYTE_ZERO;
      page_num  = '0;
      seq_pos   = '0;
      xfer_mode = (rq.kind == KIND_FLUSH) ? MODE_FLUSH : MODE_CLEAR;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Queues, counters and the mismatch report.
  // ---------------------------------------------------------------------
  in_item_t  req_q[$];       // requests waiting for the driver
  out_item_t sym_q[$];       // symbols predicted, oldest first
  int n_err = 0;
  int n_req = 0;
  int n_syms = 0;
  int n_cell_done = 0;
  int n_page_done = 0;
  int n_busy = 0;
  int n_range = 0;
  int cycles = 0;

  task automatic flag_mismatch(input string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    n_err++;
  endtask

  // ---------------------------------------------------------------------
  // Driver: bursts of requests with random gaps; a stalled transaction
  // is held untouched. Prediction happens at the accepting edge, and
  // finished transfers are counted there, just before the shadow moves on.
  // ---------------------------------------------------------------------
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        if (in_item.kind == KIND_ADVANCE) begin
          if (xfer_mode == MODE_CELL && seq_pos == 8'd9) n_cell_done++;
          if ((xfer_mode == MODE_FLUSH || xfer_mode == MODE_CLEAR) &&
              int'(seq_pos) == PAGE_SYMS - 1 && int'(page_num) == NPAGE - 1)
            n_page_done++;
        end
        sym_q.push_back(step_sequencer(in_item));
        n_req++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (req_q.size() > 0) begin
          in_item  <= req_q.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            // new burst; a third of them follow on without a gap
            burst_left = $urandom_range(0, 20);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern: free-running, coin-flip random or mostly-stalled
  // stretches of random length.
  int stall_mode = 0;
  int stall_run = 0;

  always @(posedge clk) begin
    if (stall_run == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_run  = $urandom_range(8, 64);
    end else begin
      stall_run--;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= $urandom_range(0, 1);
      default: out_stall <= ($urandom_range(0, 5) != 0);
    endcase
  end

  // ---------------------------------------------------------------------
  // Monitor: every accepted result against the oldest prediction.
  // ---------------------------------------------------------------------
  out_item_t want;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (sym_q.size() == 0) begin
        flag_mismatch("result transaction with nothing predicted");
      end else begin
        want = sym_q.pop_front();
        n_syms++;
        if (out_item.sym_kind !== want.sym_kind)
          flag_mismatch($sformatf("result %0d sym_kind %0d, predicted %0d",
                                  n_syms, out_item.sym_kind, want.sym_kind));
        if (out_item.sym_byte !== want.sym_byte)
          flag_mismatch($sformatf("result %0d sym_byte %02h, predicted %02h",
                                  n_syms, out_item.sym_byte, want.sym_byte));
        if (out_item.status !== want.status)
          flag_mismatch($sformatf("result %0d status %0d, predicted %0d",
                                  n_syms, out_item.status, want.status));
        if (out_item.last !== want.last)
          flag_mismatch($sformatf("result %0d last %0b, predicted %0b",
                                  n_syms, out_item.last, want.last));
        if (want.status == STATUS_BUSY) n_busy++;
        if (want.status == STATUS_RANGE) n_range++;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------
  task automatic push_req(input logic [1:0] k, input int x, input int y, input int on);
    in_item_t it;
    it.kind     = k;
    it.pos_x    = x[6:0];
    it.pos_y    = y[5:0];
    it.pixel_on = on[0];
    req_q.push_back(it);
  endtask

  task automatic push_advance();
    push_req(KIND_ADVANCE, $urandom_range(0, 127), $urandom_range(0, 63),
             $urandom_range(0, 1));
  endtask

  // A draw, flush or clear with random fields; only issued mid-transfer,
  // where it must bounce as busy.
  task automatic push_busy_noise();
    int pick;
    logic [1:0] k;
    pick = $urandom_range(0, 2);
    k = (pick == 0) ? KIND_DRAW : (pick == 1) ? KIND_FLUSH : KIND_CLEAR;
    push_req(k, $urandom_range(0, 127), $urandom_range(0, 63), $urandom_range(0, 1));
  endtask

  // Flush or clear followed by every symbol of all pages, with the odd
  // rejected request mixed in.
  task automatic push_page_set(input logic [1:0] k, input int on);
    push_req(k, $urandom_range(0, 127), $urandom_range(0, 63), on);
    for (int i = 0; i < NPAGE * PAGE_SYMS; i++) begin
      if ($urandom_range(0, 63) == 0) push_busy_noise();
      push_advance();
    end
  endtask

  // Waits until every queued request was sent and every result came back.
  // Sampled at the falling edge so the driver's updates have settled.
  task automatic wait_drained();
    do @(negedge clk);
    while (req_q.size() != 0 || in_valid || sym_q.size() != 0);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input int val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[7:0];
    case (idx)
      CFG_WIDTH_LIMIT:  lim_w = val[7:0];
      CFG_HEIGHT_LIMIT: lim_h = val[6:0];
      CFG_AUTO_FLUSH:   auto_send = val[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Only called with the block idle.
  task automatic set_limits(input int w, input int h, input int af);
    cfg_write(CFG_WIDTH_LIMIT, w);
    cfg_write(CFG_HEIGHT_LIMIT, h);
    cfg_write(CFG_AUTO_FLUSH, af);
  endtask

  // ---------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------
  initial begin
    int w;
    int h;
    int af;
    int pick;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: corner pixels, bit clear, idle advance.
    set_limits(128, 64, 0);
    push_req(KIND_DRAW, 0, 0, 1);
    push_req(KIND_DRAW, 127, 63, 1);
    push_req(KIND_DRAW, 127, 63, 0);
    push_req(KIND_DRAW, 127, 56, 1);
    push_advance();
    wait_drained();

    // Directed: tightest limits, range rejects, one cell transfer with
    // busy rejects of every request kind, then an idle advance.
    set_limits(1, 1, 1);
    push_req(KIND_DRAW, 1, 0, 1);
    push_req(KIND_DRAW, 0, 1, 0);
    push_req(KIND_DRAW, 127, 63, 1);
    push_req(KIND_DRAW, 0, 0, 1);
    push_req(KIND_FLUSH, 5, 5, 0);
    push_req(KIND_CLEAR, 5, 5, 1);
    push_req(KIND_DRAW, 0, 0, 0);
    repeat (11) push_advance();
    wait_drained();

    // Random phases. Odd phases and phase 6 (full size, as is phase 0) send a
    // cell per in-range draw; phase 4 ends with all pages sent, as a flush of
    // the store or a clear at a random fill level.
    for (int ph = 0; ph < 8; ph++) begin
      w  = (ph == 0 || ph == 6) ? 128 : (ph == 2) ? 1 : $urandom_range(1, 128);
      h  = (ph == 0 || ph == 6) ? 64 : (ph == 3) ? 1 : $urandom_range(1, 64);
      af = (ph % 2 == 1 || ph == 6) ? 1 : 0;
      set_limits(w, h, af);
      while (req_q.size() < 20) begin
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          push_req(KIND_DRAW, $urandom_range(0, w - 1), $urandom_range(0, h - 1),
                   $urandom_range(0, 1));
          if (af) begin
            for (int k = 0; k < 10; k++) begin
              if ($urandom_range(0, 5) == 0) push_busy_noise();
              push_advance();
            end
          end
        end else if (pick < 9 && (w < 128 || h < 64)) begin
          // point beyond one of the limits
          if (h == 64 || (w < 128 && $urandom_range(0, 1) == 0))
            push_req(KIND_DRAW, $urandom_range(w, 127), $urandom_range(0, 63),
                     $urandom_range(0, 1));
          else
            push_req(KIND_DRAW, $urandom_range(0, 127), $urandom_range(h, 63),
                     $urandom_range(0, 1));
        end else begin
          push_advance();
        end
      end
      if (ph == 4)
        push_page_set(($urandom_range(0, 1) == 0) ? KIND_FLUSH : KIND_CLEAR,
                      $urandom_range(0, 1));
      wait_drained();
    end

    // Let anything stray surface before the verdict.
    repeat (12) @(posedge clk);
    $display("Checked %0d requests and %0d symbol transactions: %0d cell transfers, %0d full page sets.",
             n_req, n_syms, n_cell_done, n_page_done);
    $display("Rejected requests seen: %0d busy, %0d out of range.", n_busy, n_range);
    if (n_err == 0 && sym_q.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

### page_framebuffer_i2c_sequencer_core.f
+incdir+hw/rtl
hw/rtl/pfbseq_pkg.sv
hw/rtl/pfbseq_store.sv
hw/rtl/pfbseq_useq.sv
hw/rtl/page_framebuffer_i2c_sequencer_core.sv
tb/tb.sv
